>>> hw/rtl/crse_pkg.sv
`default_nettype none
package crse_pkg;

  // table size; the index and count widths below follow from it
  localparam int MAX_PTS     = 32;
  localparam int CNT_W       = $clog2(MAX_PTS + 1);
  localparam int IDX_W       = $clog2(MAX_PTS);

  // fixed field widths of the request and result
  localparam int CMD_W       = 2;
  localparam int COORD_W     = 16;
  localparam int POINT_W     = 2 * COORD_W;
  localparam int TIDX_W      = 5;
  localparam int FRAC_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int COUNT_NOW_W = 6;

  // index arithmetic width: holds t_index + 3 and the count
  localparam int SUM_W       = ((CNT_W > TIDX_W) ? CNT_W : TIDX_W) + 2;

  // datapath widths
  localparam int FPROD_W     = 2 * FRAC_W;
  localparam int Q_W         = FRAC_W + 4;
  localparam int PRD_W       = COORD_W + Q_W;
  localparam int ACC_W       = PRD_W + 2;
  localparam int OUT_SHIFT   = FRAC_W + 1;
  localparam int Q_TWO       = 2 << FRAC_W;
  localparam int COORD_MAX   = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN   = -(1 << (COORD_W - 1));

  // request queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // configuration space
  localparam int CFG_AW        = 3;
  localparam int REG_LOOP_MODE = 0;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_EVAL   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [TIDX_W-1:0]         t_index;
    logic [FRAC_W-1:0]         t_frac;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_NOW_W-1:0]    count_now;
  } out_item_t;

  // classified request as handed from front to back
  typedef struct packed {
    logic                       is_eval;
    logic [STATUS_W-1:0]        status;
    logic [COUNT_NOW_W-1:0]     count_now;
    logic [3:0][IDX_W-1:0]      ix;
    logic [FRAC_W-1:0]          frac;
    logic [FRAC_W-1:0]          tt;
  } job_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   addr;
    logic [POINT_W-1:0] data;
  } ram_wr_t;

endpackage
`default_nettype wire

>>> hw/rtl/catmull_rom_spline_eval.sv
// Append, clear, range error and unused command pass the request queue and the output
// register; an evaluate also passes the back end. Throughput: one non-evaluate
// request per cycle while the queue has room and the output is not stalled; an
// evaluate holds the back end (tt*f, basis, four point reads through the single read
// port, saturate). A clear is held off until the queue is empty and back end idle.
// Reset empties the table, clears loop_mode and the queue; point memory is left as is.
`default_nettype none
module catmull_rom_spline_eval (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  crse_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output crse_pkg::out_item_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [crse_pkg::CFG_AW-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import crse_pkg::*;

  logic               cfg_sel;
  logic               cfg_we;
  logic               loop_mode;
  logic               q_full, q_empty, q_push, q_pop;
  job_t               q_wdata, q_head;
  logic               back_idle;
  logic               drained;
  ram_wr_t            ram_wr;
  logic [IDX_W-1:0]   raddr;
  logic [POINT_W-1:0] rdata;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[CFG_AW-1:2] == (CFG_AW - 2)'(REG_LOOP_MODE));
  assign cfg_we  = psel && penable && pwrite && pready && cfg_sel;
  assign prdata  = cfg_sel ? {31'b0, loop_mode} : 32'b0;
  assign drained = q_empty && back_idle;

  crse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_loop  (pwdata[0]),
    .loop_mode (loop_mode),
    .q_full    (q_full),
    .drained   (drained),
    .push      (q_push),
    .job       (q_wdata),
    .ram_wr    (ram_wr)
  );

  crse_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  crse_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_PTS)
  ) u_points (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  crse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (q_pop),
    .idle      (back_idle),
    .raddr     (raddr),
    .rdata     (rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> hw/rtl/crse_ram.sv
`default_nettype none
module crse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> hw/rtl/crse_fifo.sv
`default_nettype none
module crse_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  crse_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output crse_pkg::job_t rdata,
  output logic           empty
);
  import crse_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("request queue underflow");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("request queue count lost a push");

endmodule
`default_nettype wire

>>> hw/rtl/crse_front.sv
`default_nettype none
module crse_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  crse_pkg::in_item_t in_data,
  input  logic               cfg_we,
  input  logic               cfg_loop,
  output logic               loop_mode,
  input  logic               q_full,
  input  logic               drained,
  output logic               push,
  output crse_pkg::job_t     job,
  output crse_pkg::ram_wr_t  ram_wr
);
  import crse_pkg::*;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               loop_r, loop_nxt;
  logic               accept;
  logic               room;
  logic               ok;
  logic [SUM_W-1:0]   n_w, idx_w;
  logic [SUM_W-1:0]   i1p, i2, i2p, i3, i0;
  logic [3:0][IDX_W-1:0] ix_w;
  logic [FPROD_W-1:0] ff;

  // a clear waits until the back end has finished reading the table
  assign in_ready  = !q_full && !((in_data.cmd == CMD_CLEAR) && !drained);
  assign accept    = in_valid && in_ready;
  assign push      = accept;
  assign loop_mode = loop_r;
  assign room      = (count_r < CNT_W'(MAX_PTS));

  // neighbor indices, wrapped for a closed curve
  always_comb begin
    n_w   = SUM_W'(count_r);
    idx_w = SUM_W'(in_data.t_index);
    i1p   = idx_w + 1'b1;
    i2    = (i1p == n_w) ? '0 : i1p;
    i2p   = i2 + 1'b1;
    i3    = (i2p == n_w) ? '0 : i2p;
    i0    = (idx_w == '0) ? n_w - 1'b1 : idx_w - 1'b1;
    if (loop_r) begin
      ok       = (n_w != '0) && (idx_w < n_w);
      ix_w[0] = IDX_W'(i0);
      ix_w[1] = IDX_W'(idx_w);
      ix_w[2] = IDX_W'(i2);
      ix_w[3] = IDX_W'(i3);
    end else begin
      ok       = (idx_w + SUM_W'(3)) < n_w;
      ix_w[0] = IDX_W'(idx_w);
      ix_w[1] = IDX_W'(idx_w + SUM_W'(1));
      ix_w[2] = IDX_W'(idx_w + SUM_W'(2));
      ix_w[3] = IDX_W'(idx_w + SUM_W'(3));
    end
  end

  assign ff = FPROD_W'(in_data.t_frac) * FPROD_W'(in_data.t_frac);

  always_comb begin
    count_nxt   = count_r;
    loop_nxt    = loop_r;
    job.status  = ST_OK;
    ram_wr.we   = 1'b0;
    ram_wr.addr = count_r[IDX_W-1:0];
    ram_wr.data = {in_data.point_y, in_data.point_x};
    if (cfg_we) begin
      loop_nxt = cfg_loop;
    end
    if (accept) begin
      case (cmd_t'(in_data.cmd))
        CMD_APPEND: begin
          if (room) begin
            ram_wr.we = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            job.status = ST_FULL;
          end
        end
        CMD_CLEAR: begin
          count_nxt = '0;
          loop_nxt  = 1'b0;
        end
        CMD_EVAL: begin
          if (!ok) begin
            job.status = ST_RANGE;
          end
        end
        default: begin
        end
      endcase
    end
    job.is_eval   = (in_data.cmd == CMD_EVAL) && ok;
    job.count_now = COUNT_NOW_W'(count_nxt);
    job.ix        = ix_w;
    job.frac      = in_data.t_frac;
    job.tt        = ff[FPROD_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      loop_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      loop_r  <= loop_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/crse_back.sv
`default_nettype none
module crse_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  crse_pkg::job_t                  q_head,
  output logic                            pop,
  output logic                            idle,
  output logic [crse_pkg::IDX_W-1:0]      raddr,
  input  logic [crse_pkg::POINT_W-1:0]    rdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output crse_pkg::out_item_t             out_data
);
  import crse_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  typedef logic signed [Q_W-1:0] coef_t;

  localparam logic [2:0] STEP_TTT  = 3'd0;
  localparam logic [2:0] STEP_COEF = 3'd1;
  localparam logic [2:0] STEP_MAC0 = 3'd2;
  localparam logic [2:0] STEP_LAST = 3'd5;

  state_t                  state_r, state_nxt;
  logic [2:0]              step_r, step_nxt;
  job_t                    job_r, job_nxt;
  logic [FRAC_W-1:0]       ttt_r, ttt_nxt;
  coef_t                   q_r [4];
  coef_t                   q_nxt [4];
  logic signed [ACC_W-1:0] acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic                    out_free;
  logic [FPROD_W-1:0]      tf;
  coef_t                   sf, stt, sttt, qs;
  logic signed [COORD_W-1:0] px, py;
  logic signed [PRD_W-1:0] prod_x, prod_y;
  logic signed [ACC_W-1:0] acc_x_base, acc_y_base;

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    s  = v >>> OUT_SHIFT;
    hi = ACC_W'(COORD_MAX);
    lo = ACC_W'(COORD_MIN);
    if (s > hi) begin
      return COORD_W'(COORD_MAX);
    end else if (s < lo) begin
      return COORD_W'(COORD_MIN);
    end
    return s[COORD_W-1:0];
  endfunction

  assign out_free  = !out_valid_r || out_ready;
  assign idle      = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // points are read one step ahead of their multiply-accumulate
  assign raddr = job_r.ix[2'(step_r - STEP_COEF)];
  assign qs    = q_r[2'(step_r - STEP_MAC0)];
  assign px    = $signed(rdata[COORD_W-1:0]);
  assign py    = $signed(rdata[POINT_W-1:COORD_W]);
  assign prod_x = px * qs;
  assign prod_y = py * qs;
  assign acc_x_base = (step_r == STEP_MAC0) ? '0 : acc_x_r;
  assign acc_y_base = (step_r == STEP_MAC0) ? '0 : acc_y_r;

  assign tf   = FPROD_W'(job_r.tt) * FPROD_W'(job_r.frac);
  assign sf   = $signed(Q_W'(job_r.frac));
  assign stt  = $signed(Q_W'(job_r.tt));
  assign sttt = $signed(Q_W'(ttt_r));

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    job_nxt       = job_r;
    ttt_nxt       = ttt_r;
    q_nxt         = q_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          if (q_head.is_eval) begin
            pop       = 1'b1;
            job_nxt   = q_head;
            step_nxt  = STEP_TTT;
            state_nxt = S_RUN;
          end else if (out_free) begin
            pop                    = 1'b1;
            out_valid_nxt          = 1'b1;
            out_data_nxt.curve_x   = '0;
            out_data_nxt.curve_y   = '0;
            out_data_nxt.status    = q_head.status;
            out_data_nxt.count_now = q_head.count_now;
          end
        end
      end
      S_RUN: begin
        if (step_r == STEP_TTT) begin
          ttt_nxt = tf[FPROD_W-1:FRAC_W];
        end else if (step_r == STEP_COEF) begin
          q_nxt[0] = -sttt + (stt <<< 1) - sf;
          q_nxt[1] = (sttt <<< 1) + sttt - (stt <<< 2) - stt + Q_W'(Q_TWO);
          q_nxt[2] = -(sttt <<< 1) - sttt + (stt <<< 2) + sf;
          q_nxt[3] = sttt - stt;
        end else begin
          acc_x_nxt = acc_x_base + ACC_W'(prod_x);
          acc_y_nxt = acc_y_base + ACC_W'(prod_y);
        end
        if (step_r == STEP_LAST) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.curve_x   = sat_coord(acc_x_r);
          out_data_nxt.curve_y   = sat_coord(acc_y_r);
          out_data_nxt.status    = job_r.status;
          out_data_nxt.count_now = job_r.count_now;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    ttt_r      <= ttt_nxt;
    q_r        <= q_nxt;
    acc_x_r    <= acc_x_nxt;
    acc_y_r    <= acc_y_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import crse_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1450;

  // Tracks the point table and loop setting, predicts one result per request.
  class spline_predictor;
    logic signed [COORD_W-1:0] px[MAX_PTS];
    logic signed [COORD_W-1:0] py[MAX_PTS];
    int unsigned n_pts;
    bit loop_on;
    out_item_t pending_results[$];
    int errors;

    function new();
      n_pts = 0;
      loop_on = 0;
      errors = 0;
      for (int i = 0; i < MAX_PTS; i++) begin
        px[i] = '0;
        py[i] = '0;
      end
    endfunction

    function void set_loop_mode(bit on);
      loop_on = on;
    endfunction

    function logic signed [COORD_W-1:0] clamp16(longint v);
      if (v > COORD_MAX) return COORD_W'(COORD_MAX);
      if (v < COORD_MIN) return COORD_W'(COORD_MIN);
      return v[COORD_W-1:0];
    endfunction

    function void take_request(in_item_t req);
      out_item_t res;
      longint f, tt, ttt, sx, sy;
      longint q[4];
      int unsigned ix[4];
      bit ok;
      int unsigned idx;
      res = '0;
      res.status = ST_OK;
      case (cmd_t'(req.cmd))
        CMD_APPEND: begin
          if (n_pts < MAX_PTS) begin
            px[n_pts] = req.point_x;
            py[n_pts] = req.point_y;
            n_pts++;
          end else begin
            res.status = ST_FULL;
          end
        end
        CMD_CLEAR: begin
          for (int i = 0; i < MAX_PTS; i++) begin
            px[i] = '0;
            py[i] = '0;
          end
          n_pts = 0;
          loop_on = 0;
        end
        CMD_EVAL: begin
          idx = req.t_index;
          if (loop_on) begin
            ok = (n_pts >= 1) && (idx < n_pts);
            if (ok) begin
              ix[1] = idx;
              ix[2] = (idx + 1) % n_pts;
              ix[3] = (ix[2] + 1) % n_pts;
              ix[0] = (idx >= 1) ? idx - 1 : n_pts - 1;
            end
          end else begin
            ok = (idx + 3) < n_pts;
            for (int k = 0; k < 4; k++) ix[k] = idx + k;
          end
          if (!ok) begin
            res.status = ST_RANGE;
          end else begin
            f = longint'(req.t_frac);
            tt = (f * f) >> 16;
            ttt = (tt * f) >> 16;
            q[0] = -ttt + 2 * tt - f;
            q[1] = 3 * ttt - 5 * tt + 2 * 65536;
            q[2] = -3 * ttt + 4 * tt + f;
            q[3] = ttt - tt;
            sx = 0;
            sy = 0;
            for (int k = 0; k < 4; k++) begin
              sx += longint'(px[ix[k]]) * q[k];
              sy += longint'(py[ix[k]]) * q[k];
            end
            // floor division by 2^17
            res.curve_x = clamp16(sx >>> OUT_SHIFT);
            res.curve_y = clamp16(sy >>> OUT_SHIFT);
          end
        end
        default: ;
      endcase
      res.count_now = COUNT_NOW_W'(n_pts);
      pending_results.push_back(res);
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: x=%0d y=%0d status=%0d count=%0d",
               got.curve_x, got.curve_y, got.status, got.count_now);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.curve_x !== want.curve_x) begin
        $error("curve_x: expected %0d, got %0d", want.curve_x, got.curve_x);
        errors++;
      end
      if (got.curve_y !== want.curve_y) begin
        $error("curve_y: expected %0d, got %0d", want.curve_y, got.curve_y);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.count_now !== want.count_now) begin
        $error("count_now: expected %0d, got %0d", want.count_now, got.count_now);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  spline_predictor tracker = new();
  int unsigned cycle_count = 0;
  int burst_left = 0;
  int items_sent = 0;
  bit hold_req = 0;

  catmull_rom_spline_eval uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // outputs settle well before the falling edge; a beat seen there is taken at the next rise
  initial begin
    forever begin
      @(negedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) tracker.match_result(out_data);
    end
  end

  // result side back-pressure: patterns that change every so often, plus one long hold
  initial begin
    int hold_left;
    int mode_left;
    int mode;
    hold_left = 0;
    mode_left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (cycle_count % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic in_item_t make_request(cmd_t op, int x, int y, int idx, int frac);
    in_item_t r;
    r.cmd = op;
    r.point_x = COORD_W'(x);
    r.point_y = COORD_W'(y);
    r.t_index = TIDX_W'(idx);
    r.t_frac = FRAC_W'(frac);
    return r;
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return $urandom_range(0, 64) - 32;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  function automatic int pick_frac();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 16'hffff;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // must be called at a rising edge; returns at the edge where the request is taken
  task automatic send_request(in_item_t req);
    int gap;
    bit took;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= req;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    tracker.take_request(req);
    if (req.cmd != CMD_NONE) items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_loop_mode(bit on);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(4 * REG_LOOP_MODE);
    pwdata <= {31'd0, on};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_loop_mode(on);
  endtask

  task automatic run_session();
    in_item_t r;
    int n_app;
    int n_mixed;
    int n;
    int idx;
    n_app = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 12);
    for (int i = 0; i < n_app; i++) begin
      r = make_request(CMD_APPEND, pick_coord(), pick_coord(), $urandom_range(0, 31),
                       $urandom_range(0, 65535));
      send_request(r);
    end
    n_mixed = $urandom_range(10, 60);
    for (int i = 0; i < n_mixed; i++) begin
      n = tracker.n_pts;
      idx = $urandom_range(0, 31);
      if (tracker.loop_on && n >= 1) idx = $urandom_range(0, n - 1);
      if (!tracker.loop_on && n >= 4) idx = $urandom_range(0, n - 4);
      r = make_request(CMD_EVAL, pick_coord(), pick_coord(), idx, pick_frac());
      case ($urandom_range(0, 99)) inside
        [0:9]:   r.t_index = TIDX_W'($urandom_range(0, 31));
        [10:14]: begin
          r.cmd = CMD_APPEND;
          r.point_x = COORD_W'(pick_coord());
          r.point_y = COORD_W'(pick_coord());
        end
        [15:17]: r.cmd = CMD_NONE;
        [18:19]: r.cmd = CMD_CLEAR;
        default: ;
      endcase
      send_request(r);
    end
    if ($urandom_range(0, 1) == 1) begin
      r = make_request(CMD_CLEAR, pick_coord(), pick_coord(), $urandom_range(0, 31),
                       $urandom_range(0, 65535));
      send_request(r);
    end
  endtask

  initial begin
    int session;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // open curve: empty table, unused command, extremes and overshoot into saturation
    send_request(make_request(CMD_EVAL, 0, 0, 0, 0));
    send_request(make_request(CMD_NONE, 0, 0, 0, 0));
    send_request(make_request(CMD_APPEND, COORD_MIN, COORD_MAX, 0, 0));
    send_request(make_request(CMD_APPEND, COORD_MAX, COORD_MIN, 0, 0));
    send_request(make_request(CMD_APPEND, COORD_MAX, COORD_MIN, 0, 0));
    send_request(make_request(CMD_APPEND, COORD_MIN, COORD_MAX, 0, 0));
    send_request(make_request(CMD_EVAL, 0, 0, 0, 0));
    send_request(make_request(CMD_EVAL, 0, 0, 0, 16'hffff));
    send_request(make_request(CMD_EVAL, 0, 0, 0, 16'h8000));
    send_request(make_request(CMD_EVAL, 0, 0, 1, 16'h1234));
    send_request(make_request(CMD_EVAL, 0, 0, 31, 16'hffff));
    wait_idle();

    // closed curve: wrap on both sides, then a clear that drops back to open mode
    write_loop_mode(1'b1);
    send_request(make_request(CMD_EVAL, 0, 0, 0, 16'h8000));
    send_request(make_request(CMD_EVAL, 0, 0, 3, 16'hc000));
    send_request(make_request(CMD_EVAL, 0, 0, 4, 16'h0001));
    send_request(make_request(CMD_APPEND, 0, 0, 0, 0));
    send_request(make_request(CMD_APPEND, -1, -1, 0, 0));
    send_request(make_request(CMD_EVAL, 0, 0, 5, 16'hffff));
    send_request(make_request(CMD_EVAL, 0, 0, 31, 16'h7fff));
    send_request(make_request(CMD_CLEAR, 0, 0, 0, 0));
    send_request(make_request(CMD_EVAL, 0, 0, 0, 16'h4000));
    wait_idle();
    write_loop_mode(1'b0);

    items_sent = 0;
    session = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_idle();
      write_loop_mode(1'($urandom_range(0, 1)));
      if (session == 2) hold_req = 1;
      run_session();
      session++;
    end

    wait_idle();
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
